@@ rtl/sha_pkg.sv @@
package sha_pkg;

  typedef enum logic [1:0] {
    CmdByte = 2'd0,
    CmdEnd  = 2'd1,
    CmdBoth = 2'd2
  } sha_cmd_e;

  typedef struct packed {
    sha_cmd_e   cmd;
    logic [7:0] data;
  } sha_req_t;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StRound   = 3'd1,
    StAdd     = 3'd2,
    StPad     = 3'd3,
    StEmit    = 3'd4
  } sha_state_e;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

@@ rtl/sha_front.sv @@
module sha_front
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_message_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output sha_req_t   q_req_o
);

  sha_req_t   mem_q [4];
  logic [2:0] wr_q, wr_d, rd_q, rd_d;
  logic       push;
  sha_req_t   req;

  always_comb begin
    if (end_of_message_i && byte_present_i) begin
      req.cmd = CmdBoth;
    end else if (end_of_message_i) begin
      req.cmd = CmdEnd;
    end else begin
      req.cmd = CmdByte;
    end
    req.data = data_byte_i;
  end

  assign in_stall_o = (wr_q[1:0] == rd_q[1:0]) && (wr_q[2] != rd_q[2]);
  assign push = in_valid_i && !in_stall_o && (byte_present_i || end_of_message_i);
  assign q_valid_o = wr_q != rd_q;
  assign q_req_o = mem_q[rd_q[1:0]];
  assign wr_d = push ? wr_q + 3'd1 : wr_q;
  assign rd_d = q_pop_i ? rd_q + 3'd1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q[1:0]] <= req;
    end
  end

endmodule

@@ rtl/sha_back.sv @@
module sha_back
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  sha_req_t    q_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_state_e  st_q, st_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [60:0] len_q;
  logic        fin_q;
  logic        pad_q;
  logic        tail_q;
  logic [2:0]  idx_q;
  logic        byte_go, pad_go, blk_full;
  logic [7:0]  byte_val;
  logic [63:0] bits;
  logic [31:0] w_new, t1, t2, s0, s1, e, a, wn;

  assign bits = {len_q, 3'b000};
  assign blk_full = fill_q == 6'd63;

  always_comb begin
    byte_val = q_req_i.data;
    if (st_q == StPad) begin
      if (!pad_q) begin
        byte_val = PadByte;
      end else if (tail_q && fill_q >= LenPos) begin
        byte_val = bits[6'(63 - 8 * 32'(fill_q - LenPos)) -: 8];
      end else begin
        byte_val = 8'h00;
      end
    end
  end

  assign byte_go = st_q == StIdle && q_valid_i && q_req_i.cmd != CmdEnd && !fin_q;
  assign pad_go = st_q == StPad;

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          if (q_req_i.cmd == CmdByte) begin
            q_pop_o = 1'b1;
            if (blk_full) begin
              st_d = StRound;
            end
          end else if (q_req_i.cmd == CmdBoth && !fin_q) begin
            if (blk_full) begin
              st_d = StRound;
            end
          end else begin
            q_pop_o = 1'b1;
            st_d = StPad;
          end
        end
      end
      StPad: begin
        if (blk_full) begin
          st_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == 6'd63) begin
          st_d = StAdd;
        end
      end
      StAdd: begin
        if (pad_q && tail_q) begin
          st_d = StEmit;
        end else if (pad_q) begin
          st_d = StPad;
        end else begin
          st_d = StIdle;
        end
      end
      StEmit: begin
        if (!out_stall_i && idx_q == 3'd7) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign e = v_q[4];
  assign a = v_q[0];
  assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
  assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
            ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[rnd_q] + w_q[0];
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign wn = {w_q[15][23:0], byte_val};

  assign out_valid_o = st_q == StEmit;
  assign digest_word_o = h_q[idx_q];
  assign word_index_o = idx_q;
  assign last_word_o = idx_q == 3'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      fill_q <= '0;
      rnd_q <= '0;
      len_q <= '0;
      fin_q <= 1'b0;
      pad_q <= 1'b0;
      tail_q <= 1'b0;
      idx_q <= '0;
      h_q <= InitHash;
    end else begin
      st_q <= st_d;
      if (byte_go || pad_go) begin
        fill_q <= fill_q + 6'd1;
      end
      if (byte_go) begin
        len_q <= len_q + 61'd1;
      end
      if (st_q == StIdle && q_valid_i && q_req_i.cmd != CmdByte) begin
        fin_q <= 1'b1;
      end
      if (pad_go) begin
        pad_q <= 1'b1;
        if (!pad_q) begin
          tail_q <= fill_q < LenPos;
        end
      end
      if (st_q == StRound) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (st_q == StAdd) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
        if (pad_q && !tail_q) begin
          tail_q <= 1'b1;
        end
        if (pad_q && tail_q) begin
          idx_q <= '0;
        end
      end
      if (st_q == StEmit && !out_stall_i) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          h_q <= InitHash;
          fin_q <= 1'b0;
          pad_q <= 1'b0;
          tail_q <= 1'b0;
          fill_q <= '0;
          len_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StRound) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else begin
      if (byte_go || pad_go) begin
        if (fill_q[1:0] == 2'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_q[i] <= w_q[i + 1];
          end
        end
        w_q[15] <= wn;
      end
      v_q <= h_q;
    end
  end

endmodule

@@ rtl/sha256_stream_hasher_unit.sv @@
// A byte request passes through a queue register and is then taken by the back end when it
// is idle; the byte that completes a block adds 64 rounds and a hash update step.
// An end request pads at one byte per cycle to the block boundary (a second block when fewer
// than nine bytes remain free), compresses, then offers one digest word per unstalled cycle.
// Bytes wait while a block compresses; a four-entry queue lets input run ahead.
// Reset is asynchronous and active low; it loads the initial hash and empties the queue.
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic     q_valid, q_pop;
  sha_req_t q_req;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .byte_present_i,
    .end_of_message_i, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

endmodule
